// File: rtl/dpsu_pkg.sv
// Package for the double-precision shift unit: word types, stage
// payload types and flag bit positions. No dependencies.
`default_nettype none

package dpsu_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned HALF_W  = 16;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned FLAG_W  = 5;

  localparam int unsigned FL_CF = 0;
  localparam int unsigned FL_PF = 1;
  localparam int unsigned FL_ZF = 2;
  localparam int unsigned FL_SF = 3;
  localparam int unsigned FL_OF = 4;

  localparam logic OP_SHLD = 1'b0;
  localparam logic OP_SHRD = 1'b1;

  typedef struct packed {
    logic              operation;
    logic              wide;
    logic [DATA_W-1:0] dest_value;
    logic [DATA_W-1:0] fill_value;
    logic [7:0]        count_raw;
    logic [FLAG_W-1:0] flags_in;
  } cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0] result;
    logic              write_dest;
    logic [FLAG_W-1:0] flags_out;
  } rsp_t;

  typedef struct packed {
    logic              right;
    logic              wide;
    logic              skip;
    logic              ovf;
    logic [CNT_W-1:0]  cnt;
    logic [DATA_W-1:0] dval;
    logic [DATA_W-1:0] fval;
    logic [FLAG_W-1:0] flags_in;
  } dec_t;

  typedef struct packed {
    logic              wide;
    logic              skip;
    logic              cf;
    logic              ovf;
    logic [DATA_W-1:0] value;
    logic [FLAG_W-1:0] flags_in;
  } shf_t;

endpackage

`default_nettype wire

// File: rtl/double_precision_shift_unit.sv
// Top level of the double-precision shift unit (SHLD / SHRD, 16 or 32 bit).
// Depends on dpsu_pkg, dpsu_decode, dpsu_shift and dpsu_flags.
//
// Usage:
//   Command channel cmd_valid / cmd_stall / cmd carries one instruction word:
//   operation, operand size, destination, fill source, raw count and flags.
//   Response channel res_valid / res_stall / res returns one word per
//   command: the shifted result, the destination write enable and new flags.
//   A word moves on a rising edge with valid high and stall low.
//   A command passes the decode, funnel shift and flag stages in turn.
//   One command is taken every cycle while cmd_stall is low; each stage
//   advances whenever it is empty or the next stage takes its word.
//   When the receiver stalls, the response holds and the stages fill up;
//   cmd_stall rises once all three stages hold a word, and nothing is lost.
//   Reset clears all stage valid bits; the first command can follow at once.
`default_nettype none

module double_precision_shift_unit (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      cmd_valid,
  output logic           cmd_stall,
  input  wire dpsu_pkg::cmd_t cmd,
  output logic           res_valid,
  input  wire logic      res_stall,
  output dpsu_pkg::rsp_t res
);
  import dpsu_pkg::*;

  logic dec_ready;
  logic dec_valid;
  dec_t dec_word;
  logic shf_ready;
  logic shf_valid;
  shf_t shf_word;
  logic flg_ready;

  dpsu_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (cmd_valid),
    .up_ready   (dec_ready),
    .up_word    (cmd),
    .down_valid (dec_valid),
    .down_ready (shf_ready),
    .down_word  (dec_word)
  );

  dpsu_shift u_shift (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (dec_valid),
    .up_ready   (shf_ready),
    .up_word    (dec_word),
    .down_valid (shf_valid),
    .down_ready (flg_ready),
    .down_word  (shf_word)
  );

  dpsu_flags u_flags (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (shf_valid),
    .up_ready   (flg_ready),
    .up_word    (shf_word),
    .down_valid (res_valid),
    .down_ready (!res_stall),
    .down_word  (res)
  );

  assign cmd_stall = !dec_ready;

endmodule

`default_nettype wire

// File: rtl/dpsu_decode.sv
// First stage: mask operands to the operand size, reduce the count and
// work out the skip case and overflow flag. Depends on dpsu_pkg.
`default_nettype none

module dpsu_decode (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          up_valid,
  output logic               up_ready,
  input  wire dpsu_pkg::cmd_t up_word,
  output logic               down_valid,
  input  wire logic          down_ready,
  output dpsu_pkg::dec_t     down_word
);
  import dpsu_pkg::*;

  localparam logic [CNT_W-1:0] HALF_CNT = CNT_W'(HALF_W);

  dec_t              word_next;
  logic [DATA_W-1:0] dm;
  logic [DATA_W-1:0] sm;
  logic [CNT_W-1:0]  cnt;
  logic              top_bit;
  logic              sub_bit;

  always_comb begin
    cnt     = up_word.count_raw[CNT_W-1:0];
    dm      = up_word.wide ? up_word.dest_value
                           : {{(DATA_W-HALF_W){1'b0}}, up_word.dest_value[HALF_W-1:0]};
    sm      = up_word.wide ? up_word.fill_value
                           : {{(DATA_W-HALF_W){1'b0}}, up_word.fill_value[HALF_W-1:0]};
    top_bit = up_word.wide ? dm[DATA_W-1] : dm[HALF_W-1];
    sub_bit = up_word.wide ? dm[DATA_W-2] : dm[HALF_W-2];

    word_next.right    = (up_word.operation == OP_SHRD);
    word_next.wide     = up_word.wide;
    word_next.skip     = (cnt == '0) || (!up_word.wide && (cnt > HALF_CNT));
    word_next.ovf      = (up_word.operation == OP_SHRD) ? (top_bit ^ sm[0])
                                                        : (top_bit ^ sub_bit);
    word_next.cnt      = cnt;
    word_next.dval     = dm;
    word_next.fval     = sm;
    word_next.flags_in = up_word.flags_in;
  end

  assign up_ready = !down_valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      down_valid <= 1'b0;
    end else if (up_ready) begin
      down_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      down_word <= word_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/dpsu_shift.sv
// Second stage: funnel shift of destination and fill operand, with the
// last bit shifted out as carry. Depends on dpsu_pkg.
`default_nettype none

module dpsu_shift (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          up_valid,
  output logic               up_ready,
  input  wire dpsu_pkg::dec_t up_word,
  output logic               down_valid,
  input  wire logic          down_ready,
  output dpsu_pkg::shf_t     down_word
);
  import dpsu_pkg::*;

  localparam int unsigned FUN_W = 2*DATA_W + 1;

  shf_t             word_next;
  logic [FUN_W-1:0] lx;
  logic [FUN_W-1:0] ly;
  logic [FUN_W-1:0] rx;
  logic [FUN_W-1:0] ry;
  logic [DATA_W-1:0] lres;
  logic [DATA_W-1:0] rres;

  always_comb begin
    // left: shift {dest, fill} up, take the top word; carry lands above it
    lx = up_word.wide
       ? {1'b0, up_word.dval, up_word.fval}
       : {1'b0, up_word.dval[HALF_W-1:0], up_word.fval[HALF_W-1:0], {DATA_W{1'b0}}};
    ly = lx << up_word.cnt;
    lres = up_word.wide ? ly[FUN_W-2 -: DATA_W]
                        : {{(DATA_W-HALF_W){1'b0}}, ly[FUN_W-2 -: HALF_W]};

    // right: shift {fill, dest} down, take the low word; carry lands below it
    rx = up_word.wide
       ? {up_word.fval, up_word.dval, 1'b0}
       : {{DATA_W{1'b0}}, up_word.fval[HALF_W-1:0], up_word.dval[HALF_W-1:0], 1'b0};
    ry = rx >> up_word.cnt;
    rres = up_word.wide ? ry[DATA_W:1]
                        : {{(DATA_W-HALF_W){1'b0}}, ry[HALF_W:1]};

    word_next.wide     = up_word.wide;
    word_next.skip     = up_word.skip;
    word_next.cf       = up_word.right ? ry[0] : ly[FUN_W-1];
    word_next.ovf      = up_word.ovf;
    word_next.value    = up_word.right ? rres : lres;
    word_next.flags_in = up_word.flags_in;
  end

  assign up_ready = !down_valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      down_valid <= 1'b0;
    end else if (up_ready) begin
      down_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      down_word <= word_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/dpsu_flags.sv
// Third stage: sign, zero and parity flags, and the skip case that keeps
// the flags and drops the write. Holds the output word. Depends on dpsu_pkg.
`default_nettype none

module dpsu_flags (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          up_valid,
  output logic               up_ready,
  input  wire dpsu_pkg::shf_t up_word,
  output logic               down_valid,
  input  wire logic          down_ready,
  output dpsu_pkg::rsp_t     down_word
);
  import dpsu_pkg::*;

  rsp_t              word_next;
  logic [FLAG_W-1:0] fl;

  always_comb begin
    fl        = '0;
    fl[FL_CF] = up_word.cf;
    fl[FL_PF] = ~^up_word.value[7:0];
    fl[FL_ZF] = (up_word.value == '0);
    fl[FL_SF] = up_word.wide ? up_word.value[DATA_W-1] : up_word.value[HALF_W-1];
    fl[FL_OF] = up_word.ovf;

    if (up_word.skip) begin
      word_next.result     = '0;
      word_next.write_dest = 1'b0;
      word_next.flags_out  = up_word.flags_in;
    end else begin
      word_next.result     = up_word.value;
      word_next.write_dest = 1'b1;
      word_next.flags_out  = fl;
    end
  end

  assign up_ready = !down_valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      down_valid <= 1'b0;
    end else if (up_ready) begin
      down_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      down_word <= word_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/dpsu_checker.sv
// Port checker for the double-precision shift unit, bound to the top level.
// Depends on dpsu_pkg and double_precision_shift_unit.
`default_nettype none

module dpsu_checker (
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      res_valid,
  input wire logic      res_stall,
  input wire dpsu_pkg::rsp_t res
);
  import dpsu_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("response changed under stall");

  a_skip_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.write_dest |-> res.result == '0)
    else $error("skipped shift returned a nonzero result");

  a_zf: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.write_dest |-> res.flags_out[FL_ZF] == (res.result == '0))
    else $error("zero flag does not match result");

  a_pf: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.write_dest |-> res.flags_out[FL_PF] == ~^res.result[7:0])
    else $error("parity flag does not match low result byte");

endmodule

bind double_precision_shift_unit dpsu_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);

`default_nettype wire
